// File: hw/rtl/lz4bd_pkg.sv
// ----------------------------------------------------------------------------
// lz4bd_pkg: shared types and constants
// Phase codes, widths and the front-to-back command record.
// ----------------------------------------------------------------------------
package lz4bd_pkg;

    localparam int CNT_W  = 23;
    localparam int HIST_AW = 16;
    localparam int HIST_DEPTH = 65536;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [2:0] PH_TOKEN  = 3'd0;
    localparam logic [2:0] PH_LITEXT = 3'd1;
    localparam logic [2:0] PH_LIT    = 3'd2;
    localparam logic [2:0] PH_DLO    = 3'd3;
    localparam logic [2:0] PH_DHI    = 3'd4;
    localparam logic [2:0] PH_MEXT   = 3'd5;
    localparam logic [2:0] PH_COPY   = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_DIST  = 2'd2;
    localparam logic [1:0] ST_SEQ   = 2'd3;

    // One classified item from the parser to the output stage.
    typedef struct packed {
        logic             emit_lit;   // write literal byte
        logic             emit_copy;  // read history and write it back
        logic [7:0]       lit_byte;
        logic [HIST_AW-1:0] src_addr;
        logic [HIST_AW-1:0] dst_addr;
        logic             copy_pending;
        logic             block_done;
        logic [1:0]       status;
        logic [CNT_W-1:0] produced;
    } cmd_t;

endpackage

// File: hw/rtl/lz4_block_decompressor_core.sv
// ----------------------------------------------------------------------------
// lz4_block_decompressor_core: LZ4 block decoder, one item per request
// Parser front end feeding a history RAM back end with a small result queue.
// ----------------------------------------------------------------------------
// Channel | Dir | Fields
// s_axis  | in  | tuser=opcode, tdata[7:0]=in_byte, tlast=in_last
// m_axis  | out | tdata: valid, byte, copy_pending, done, status, count
// apb     | in  | reg 0 at 0x0: out_limit[22:0]
//
// One request per cycle while results drain; a request that follows a match
// tick that emitted a byte waits while the copied byte is written back over
// the single history port (read, then write-back). A result is registered in
// stage 1, then in the queue. rst_n clears control state; history is not
// cleared (its contents are only read at addresses already written).
// Either side may stall; the two-entry queue absorbs the pipeline.
// ----------------------------------------------------------------------------
module lz4_block_decompressor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] opcode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] out_valid, [8:1] out_byte, [9] copy_pending, [10] block_done,
    // [12:11] status, [35:13] produced_count
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lz4bd_pkg::*;

    logic [CNT_W-1:0] limit_reg;
    logic             go;
    cmd_t             cmd;
    logic             can_take;
    logic [39:0]      q_word;

    assign pready = 1'b1;
    assign prdata = {{(32-CNT_W){1'b0}}, limit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= CNT_W'(4194304);
        else if (psel && penable && pwrite && !paddr)
            limit_reg <= pwdata[CNT_W-1:0];
    end

    assign s_axis_tready = can_take;
    assign go = s_axis_tvalid && s_axis_tready;

    lz4bd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_go     (go),
        .opcode    (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_limit (limit_reg),
        .cmd       (cmd)
    );

    lz4bd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_go   (go),
        .cmd      (cmd),
        .can_take (can_take),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (q_word)
    );

    assign m_axis_tdata = {4'd0, q_word[35:0]};

    // status never leaves an error once set
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tdata[12:11] != ST_OK)
        |=> !(m_axis_tvalid && m_axis_tdata[12:11] == ST_OK && !m_axis_tdata[10]
              && m_axis_tdata[0]))
        else $error("status cleared");
    // pending copy with a result means no done flag
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[10]))
        else $error("copy pending while done");
    // no request taken while the back end reports a full queue
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !can_take |-> !go)
        else $error("request while full");
endmodule

// File: hw/rtl/lz4bd_ram.sv
// ----------------------------------------------------------------------------
// lz4bd_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lz4bd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/lz4bd_front.sv
// ----------------------------------------------------------------------------
// lz4bd_front: LZ4 sequence parser
// Tracks phase, lengths, distance and the output count; emits one command
// per accepted item.
// ----------------------------------------------------------------------------
module lz4bd_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_go,
    input  logic                    opcode,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    input  logic [lz4bd_pkg::CNT_W-1:0] out_limit,
    output lz4bd_pkg::cmd_t         cmd
);
    import lz4bd_pkg::*;

    logic [2:0]       phase_reg, phase_next;
    logic [3:0]       mnib_reg, mnib_next;
    logic [CNT_W-1:0] lit_reg, lit_next;
    logic [CNT_W-1:0] mlen_reg, mlen_next;
    logic [15:0]      dist_reg, dist_next;
    logic [CNT_W-1:0] prod_reg, prod_next;
    logic [1:0]       err_reg, err_next;
    logic             fin_reg, fin_next;

    logic [CNT_W-1:0] len_sel;
    logic             over;
    logic [CNT_W:0]   sum_ext;
    logic [CNT_W-1:0] acc_sat;
    logic [CNT_W-1:0] acc_src;
    logic [15:0]      dist_full;

    always_comb
    begin
        acc_src = (phase_reg == PH_MEXT) ? mlen_reg : lit_reg;
        sum_ext = {1'b0, acc_src} + {{(CNT_W-7){1'b0}}, in_byte};
        acc_sat = sum_ext[CNT_W] ? CNT_MAX : sum_ext[CNT_W-1:0];
        dist_full = {in_byte, dist_reg[7:0]};
    end

    // length checked against the limit this cycle (run start only)
    always_comb
    begin
        len_sel = '0;
        case (phase_reg)
            PH_TOKEN:  len_sel = {{(CNT_W-4){1'b0}}, in_byte[7:4]};
            PH_LITEXT: len_sel = acc_sat;
            PH_DHI:    len_sel = {{(CNT_W-5){1'b0}}, 1'b0, mnib_reg} + CNT_W'(4);
            PH_MEXT:   len_sel = acc_sat;
            default:   len_sel = '0;
        endcase
        over = ({1'b0, prod_reg} + {1'b0, len_sel}) > {1'b0, out_limit};
    end

    always_comb
    begin
        phase_next = phase_reg;
        mnib_next  = mnib_reg;
        lit_next   = lit_reg;
        mlen_next  = mlen_reg;
        dist_next  = dist_reg;
        prod_next  = prod_reg;
        err_next   = err_reg;
        fin_next   = fin_reg;
        cmd = '0;
        cmd.dst_addr = prod_reg[HIST_AW-1:0];
        cmd.src_addr = prod_reg[HIST_AW-1:0] - dist_reg;
        cmd.lit_byte = in_byte;

        if (in_go && err_reg == ST_OK && !fin_reg)
        begin
            if (opcode)
            begin
                if (phase_reg == PH_COPY && mlen_reg != '0)
                begin
                    cmd.emit_copy = 1'b1;
                    prod_next = prod_reg + CNT_W'(1);
                    mlen_next = mlen_reg - CNT_W'(1);
                    if (mlen_reg == CNT_W'(1))
                        phase_next = PH_TOKEN;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_COPY: err_next = ST_SEQ;
                    PH_LIT:
                    begin
                        if (in_last && lit_reg != CNT_W'(1))
                            err_next = ST_SEQ;
                        else
                        begin
                            cmd.emit_lit = 1'b1;
                            prod_next = prod_reg + CNT_W'(1);
                            lit_next = lit_reg - CNT_W'(1);
                            if (lit_reg == CNT_W'(1))
                            begin
                                if (in_last)
                                    fin_next = 1'b1;
                                else
                                    phase_next = PH_DLO;
                            end
                        end
                    end
                    PH_TOKEN:
                    begin
                        mnib_next = in_byte[3:0];
                        if (in_last)
                        begin
                            if (in_byte[7:4] == 4'd0)
                                fin_next = 1'b1;
                            else
                                err_next = ST_SEQ;
                        end
                        else if (in_byte[7:4] == 4'd15)
                        begin
                            lit_next = CNT_W'(15);
                            phase_next = PH_LITEXT;
                        end
                        else if (in_byte[7:4] == 4'd0)
                            phase_next = PH_DLO;
                        else if (over)
                            err_next = ST_LIMIT;
                        else
                        begin
                            lit_next = len_sel;
                            phase_next = PH_LIT;
                        end
                    end
                    PH_LITEXT:
                    begin
                        if (in_last)
                            err_next = ST_SEQ;
                        else
                        begin
                            lit_next = acc_sat;
                            if (in_byte != 8'd255)
                            begin
                                if (over)
                                    err_next = ST_LIMIT;
                                else
                                    phase_next = PH_LIT;
                            end
                        end
                    end
                    PH_DLO:
                    begin
                        if (in_last)
                            err_next = ST_SEQ;
                        else
                        begin
                            dist_next = {8'd0, in_byte};
                            phase_next = PH_DHI;
                        end
                    end
                    PH_DHI:
                    begin
                        if (in_last)
                            err_next = ST_SEQ;
                        else
                        begin
                            dist_next = dist_full;
                            if (dist_full == 16'd0 ||
                                {{(CNT_W-16){1'b0}}, dist_full} > prod_reg)
                                err_next = ST_DIST;
                            else if (mnib_reg == 4'd15)
                            begin
                                mlen_next = CNT_W'(19);
                                phase_next = PH_MEXT;
                            end
                            else if (over)
                                err_next = ST_LIMIT;
                            else
                            begin
                                mlen_next = len_sel;
                                phase_next = PH_COPY;
                            end
                        end
                    end
                    PH_MEXT:
                    begin
                        if (in_last)
                            err_next = ST_SEQ;
                        else
                        begin
                            mlen_next = acc_sat;
                            if (in_byte != 8'd255)
                            begin
                                if (over)
                                    err_next = ST_LIMIT;
                                else
                                    phase_next = PH_COPY;
                            end
                        end
                    end
                    default: err_next = ST_SEQ;
                endcase
            end
        end

        cmd.copy_pending = (err_next == ST_OK) && !fin_next &&
                           (phase_next == PH_COPY) && (mlen_next != '0);
        cmd.block_done = fin_next;
        cmd.status = err_next;
        cmd.produced = prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOKEN;
            mnib_reg  <= '0;
            lit_reg   <= '0;
            mlen_reg  <= '0;
            dist_reg  <= '0;
            prod_reg  <= '0;
            err_reg   <= ST_OK;
            fin_reg   <= 1'b0;
        end
        else if (in_go)
        begin
            phase_reg <= phase_next;
            mnib_reg  <= mnib_next;
            lit_reg   <= lit_next;
            mlen_reg  <= mlen_next;
            dist_reg  <= dist_next;
            prod_reg  <= prod_next;
            err_reg   <= err_next;
            fin_reg   <= fin_next;
        end
    end
endmodule

// File: hw/rtl/lz4bd_back.sv
// ----------------------------------------------------------------------------
// lz4bd_back: history access and result queue
// Stage 1 reads or writes history; stage 2 forms the result; a two-entry
// queue holds results for the output stream.
// ----------------------------------------------------------------------------
module lz4bd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_go,
    input  lz4bd_pkg::cmd_t cmd,
    output logic            can_take,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [39:0]     m_tdata
);
    import lz4bd_pkg::*;

    // pipeline register after the RAM access
    logic       s1_vld_reg;
    cmd_t       s1_cmd_reg;
    logic [7:0] ram_q;
    logic [7:0] fwd_byte_reg;
    logic       fwd_hit_reg;

    // last written byte, for a copy that reads the byte just written
    logic [7:0]         last_wbyte_reg;
    logic [HIST_AW-1:0] last_waddr_reg;
    logic               last_wvld_reg;

    logic [7:0] wbyte;
    logic       ram_we;
    logic       ram_re;
    logic [HIST_AW-1:0] ram_addr;

    // queue of results
    logic [39:0] q_data_reg [2];
    logic        q_rd_reg, q_wr_reg;
    logic [1:0]  q_cnt_reg;

    logic [7:0]  s1_byte;
    logic [39:0] s1_word;
    logic        push, pop;

    // A copy reads history, and the read byte is written back from stage 1.
    // The write-back of stage 1 shares the port with the next command, so
    // the write of a copied byte is done in the cycle after its read.
    assign s1_byte = s1_cmd_reg.emit_copy ? (fwd_hit_reg ? fwd_byte_reg : ram_q)
                                           : s1_cmd_reg.lit_byte;

    // pending copy write-back from stage 1
    logic wb_pend;
    assign wb_pend = s1_vld_reg && s1_cmd_reg.emit_copy;

    always_comb
    begin
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_addr = cmd.dst_addr;
        wbyte = cmd.lit_byte;
        if (wb_pend)
        begin
            ram_we = 1'b1;
            ram_addr = s1_cmd_reg.dst_addr;
            wbyte = s1_byte;
        end
        else if (cmd_go && cmd.emit_lit)
        begin
            ram_we = 1'b1;
            ram_addr = cmd.dst_addr;
        end
        else if (cmd_go && cmd.emit_copy)
        begin
            ram_re = 1'b1;
            ram_addr = cmd.src_addr;
        end
    end

    lz4bd_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (wbyte),
        .rdata (ram_q)
    );

    // only one port: stall the front whenever a write-back is pending, even if
    // the next command would not need the port
    assign can_take = (q_cnt_reg == 2'd0 || (q_cnt_reg == 2'd1 && !s1_vld_reg) ||
                       (q_cnt_reg == 2'd1 && pop) || (q_cnt_reg == 2'd2 && pop && !s1_vld_reg))
                      && !wb_pend;

    assign s1_word = {4'd0, s1_cmd_reg.produced, s1_cmd_reg.status, s1_cmd_reg.block_done,
                      s1_cmd_reg.copy_pending,
                      (s1_cmd_reg.emit_lit || s1_cmd_reg.emit_copy) ? s1_byte : 8'd0,
                      s1_cmd_reg.emit_lit || s1_cmd_reg.emit_copy};

    assign push = s1_vld_reg;
    assign pop  = m_tvalid && m_tready;
    assign m_tvalid = q_cnt_reg != 2'd0;
    assign m_tdata  = q_data_reg[q_rd_reg];

    always_ff @(posedge clk)
    begin
        if (cmd_go)
            s1_cmd_reg <= cmd;
        if (push)
            q_data_reg[q_wr_reg] <= s1_word;
        if (ram_we)
        begin
            last_wbyte_reg <= wbyte;
            last_waddr_reg <= ram_addr;
        end
        fwd_hit_reg  <= ram_re && last_wvld_reg && last_waddr_reg == ram_addr &&
                        !ram_we;
        fwd_byte_reg <= last_wbyte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            q_rd_reg <= 1'b0;
            q_wr_reg <= 1'b0;
            q_cnt_reg <= 2'd0;
            last_wvld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd_go;
            if (ram_we)
                last_wvld_reg <= 1'b1;
            if (push)
                q_wr_reg <= ~q_wr_reg;
            if (pop)
                q_rd_reg <= ~q_rd_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: test/lz4_block_decompressor_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz4_block_decompressor_core_test: self-checking bench for the LZ4 decoder
// Streams well-formed LZ4 sequences with random content, plus ignored ticks,
// into the core under random stalls on both sides. A scoreboard decodes the
// same stream with its own history and compares every result field by field.
// The run closes with one randomly chosen block end: done, empty final run,
// output limit, bad distance, byte during copy or truncation.
// ----------------------------------------------------------------------------
module lz4_block_decompressor_core_test;

    import lz4bd_pkg::*;

    localparam bit OP_BYTE = 1'b0;
    localparam bit OP_TICK = 1'b1;

    localparam logic [CNT_W-1:0] LIMIT_TOP = 23'd4194304;
    localparam logic [CNT_W-1:0] LIMIT_BOTTOM = 23'd1;
    localparam logic ADDR_OUT_LIMIT = 1'b0;

    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT = 400000;

    localparam int END_DONE      = 0;
    localparam int END_EMPTY_RUN = 1;
    localparam int END_LIMIT     = 2;
    localparam int END_BAD_DIST  = 3;
    localparam int END_COPY_HIT  = 4;
    localparam int END_TRUNCATE  = 5;

    // one decoded result, packed in the same order as m_axis_tdata[35:0]
    typedef struct packed {
        logic [CNT_W-1:0] produced;
        logic [1:0]       status;
        logic             done;
        logic             pending;
        logic [7:0]       data;
        logic             valid;
    } result_t;

    typedef struct {
        bit       op;
        bit [7:0] data;
        bit       last;
    } request_t;

    // ------------------------------------------------------------------------
    // scoreboard: mirror decoder plus queue of expected results
    // ------------------------------------------------------------------------
    class lz4_scoreboard;
        bit [7:0]         hist [HIST_DEPTH];
        logic [2:0]       phase;
        logic [3:0]       match_nib;
        logic [CNT_W-1:0] lit_left;
        logic [CNT_W-1:0] match_left;
        logic [15:0]      match_dist;
        logic [CNT_W-1:0] produced;
        logic [1:0]       err;
        logic             fin;
        logic [CNT_W-1:0] limit;
        result_t          decoded_q[$];
        int               mismatches;

        function new();
            phase = PH_TOKEN;
            match_nib = '0;
            lit_left = '0;
            match_left = '0;
            match_dist = '0;
            produced = '0;
            err = ST_OK;
            fin = 1'b0;
            limit = LIMIT_TOP;
            mismatches = 0;
        endfunction

        function void fail(string msg);
            if (mismatches < 10)
                $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endfunction

        function bit over(longint unsigned len);
            return longint'(produced) + len > longint'(limit);
        endfunction

        function logic [CNT_W-1:0] sat(logic [CNT_W-1:0] a, logic [7:0] b);
            longint unsigned s;
            s = longint'(a) + b;
            return (s > longint'(CNT_MAX)) ? CNT_MAX : s[CNT_W-1:0];
        endfunction

        function void put(bit [7:0] b);
            hist[produced[HIST_AW-1:0]] = b;
            produced = produced + 1'b1;
        endfunction

        // decode one accepted request and queue what the core must return
        function void note_request(request_t rq);
            result_t r;
            r = '0;
            if (err == ST_OK && !fin) begin
                if (rq.op == OP_TICK) begin
                    if (phase == PH_COPY && match_left > 0) begin
                        r.data = hist[produced[HIST_AW-1:0] - match_dist];
                        r.valid = 1'b1;
                        put(r.data);
                        match_left--;
                        if (match_left == 0)
                            phase = PH_TOKEN;
                    end
                end else if (phase == PH_COPY) begin
                    err = ST_SEQ;
                end else if (phase == PH_LIT) begin
                    if (rq.last && lit_left != 1) begin
                        err = ST_SEQ;
                    end else begin
                        r.data = rq.data;
                        r.valid = 1'b1;
                        put(rq.data);
                        lit_left--;
                        if (lit_left == 0) begin
                            if (rq.last)
                                fin = 1'b1;
                            else
                                phase = PH_DLO;
                        end
                    end
                end else if (phase == PH_TOKEN) begin
                    match_nib = rq.data[3:0];
                    if (rq.last) begin
                        if (rq.data[7:4] == 0)
                            fin = 1'b1;
                        else
                            err = ST_SEQ;
                    end else if (rq.data[7:4] == 4'd15) begin
                        lit_left = 15;
                        phase = PH_LITEXT;
                    end else if (rq.data[7:4] == 0) begin
                        phase = PH_DLO;
                    end else if (over(rq.data[7:4])) begin
                        err = ST_LIMIT;
                    end else begin
                        lit_left = rq.data[7:4];
                        phase = PH_LIT;
                    end
                end else if (rq.last) begin
                    err = ST_SEQ;
                end else if (phase == PH_LITEXT) begin
                    lit_left = sat(lit_left, rq.data);
                    if (rq.data != 8'hFF) begin
                        if (over(lit_left))
                            err = ST_LIMIT;
                        else
                            phase = PH_LIT;
                    end
                end else if (phase == PH_DLO) begin
                    match_dist = {8'h00, rq.data};
                    phase = PH_DHI;
                end else if (phase == PH_DHI) begin
                    match_dist[15:8] = rq.data;
                    if (match_dist == 0 || match_dist > produced) begin
                        err = ST_DIST;
                    end else if (match_nib == 4'd15) begin
                        match_left = 19;
                        phase = PH_MEXT;
                    end else if (over(match_nib + 4)) begin
                        err = ST_LIMIT;
                    end else begin
                        match_left = match_nib + 4;
                        phase = PH_COPY;
                    end
                end else if (phase == PH_MEXT) begin
                    match_left = sat(match_left, rq.data);
                    if (rq.data != 8'hFF) begin
                        if (over(match_left))
                            err = ST_LIMIT;
                        else
                            phase = PH_COPY;
                    end
                end else begin
                    err = ST_SEQ;
                end
            end
            r.pending = (err == ST_OK && !fin && phase == PH_COPY && match_left > 0);
            r.done = fin;
            r.status = err;
            r.produced = produced;
            decoded_q.push_back(r);
        endfunction

        function void check_result(logic [39:0] tdata);
            result_t got, want;
            got = tdata[35:0];
            if (decoded_q.size() == 0) begin
                fail($sformatf("result with nothing expected: %h", tdata));
                return;
            end
            want = decoded_q.pop_front();
            if (got.valid !== want.valid)
                fail($sformatf("out_valid exp %0d got %0d", want.valid, got.valid));
            if (got.data !== want.data)
                fail($sformatf("out_byte exp %h got %h", want.data, got.data));
            if (got.pending !== want.pending)
                fail($sformatf("copy_pending exp %0d got %0d", want.pending, got.pending));
            if (got.done !== want.done)
                fail($sformatf("block_done exp %0d got %0d", want.done, got.done));
            if (got.status !== want.status)
                fail($sformatf("status exp %0d got %0d", want.status, got.status));
            if (got.produced !== want.produced)
                fail($sformatf("produced_count exp %0d got %0d",
                               want.produced, got.produced));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] in_byte
    logic        s_axis_tuser;    // [0] opcode
    logic        s_axis_tlast;    // in_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [0] valid, [8:1] byte, [9] pending, [10] done,
                                  // [12:11] status, [35:13] produced_count
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lz4_scoreboard sb;
    request_t      stream_q[$];   // compressed bytes and ticks waiting to go out
    int            gen_count;     // bytes the queued stream will have decoded
    int            seq_items;     // meaningful requests generated so far
    int            cycles;
    bit            steady;        // no idling on either side while set
    bit            sending;

    lz4_block_decompressor_core u_dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // every handshake on the result side goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // result sink with random back-pressure
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    function void push_req(bit op, bit [7:0] b, bit last);
        request_t rq;
        rq.op = op;
        rq.data = b;
        rq.last = last;
        stream_q.push_back(rq);
        seq_items++;
    endfunction

    // length extension bytes after a nibble of 15 (255 continues)
    function void push_ext(int rest);
        while (rest >= 255)
        begin
            push_req(OP_BYTE, 8'hFF, 1'b0);
            rest -= 255;
        end
        push_req(OP_BYTE, rest[7:0], 1'b0);
    endfunction

    // one complete sequence: token, literal run, distance, match ticks
    function void push_sequence(int lits, int mlen, int d);
        bit [3:0] lnib, mnib;
        lnib = (lits >= 15) ? 4'd15 : lits[3:0];
        mnib = (mlen >= 19) ? 4'd15 : 4'(mlen - 4);
        push_req(OP_BYTE, {lnib, mnib}, 1'b0);
        if (lits >= 15)
            push_ext(lits - 15);
        repeat (lits) push_req(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
        gen_count += lits;
        push_req(OP_BYTE, d[7:0], 1'b0);
        push_req(OP_BYTE, d[15:8], 1'b0);
        if (mlen >= 19)
            push_ext(mlen - 19);
        repeat (mlen) push_req(OP_TICK, 8'($urandom_range(0, 255)), 1'b0);
        gen_count += mlen;
        // a stray tick now and then: nothing to copy, so it is dropped
        if ($urandom_range(0, 5) == 0)
        begin
            push_req(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            seq_items--;
        end
    endfunction

    function int pick_distance();
        int top;
        top = (gen_count > 65535) ? 65535 : gen_count;
        case ($urandom_range(0, 3))
            0: return 1;
            1: return $urandom_range(1, (top < 4) ? top : 4);
            2: return top;
            default: return $urandom_range(1, top);
        endcase
    endfunction

    function void random_sequence();
        int lits, mlen, pick;
        pick = $urandom_range(0, 39);
        lits = (pick == 0) ? $urandom_range(270, 290) :
               (pick < 5) ? $urandom_range(15, 40) : $urandom_range(0, 10);
        if (gen_count == 0 && lits == 0)
            lits = 1;
        pick = $urandom_range(0, 39);
        mlen = (pick == 0) ? $urandom_range(274, 290) :
               (pick < 6) ? $urandom_range(19, 40) : $urandom_range(4, 14);
        push_sequence(lits, mlen, pick_distance());
        steady = ($urandom_range(0, 3) == 0);
    endfunction

    // drive one request; called and returning at a falling edge
    task automatic send_req(request_t rq);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rq.data;
        s_axis_tuser <= rq.op;
        s_axis_tlast <= rq.last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(rq);
        @(negedge clk);
    endtask

    task automatic drain_stream();
        while (stream_q.size() > 0)
            send_req(stream_q.pop_front());
        s_axis_tvalid <= 1'b0;
    endtask

    // wait until every expected result has come back, then let the pipe settle
    task automatic wait_idle();
        while (sb.decoded_q.size() > 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(logic [CNT_W-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_OUT_LIMIT;
        pwdata <= {9'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        sb.limit = value;
        // read back; psel stays high into the read setup cycle
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[CNT_W-1:0] !== value)
            sb.fail($sformatf("out_limit read exp %0d got %0d", value, prdata));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int ending, d;
        sb = new();
        gen_count = 0;
        seq_items = 0;
        cycles = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 1'b0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        apb_write(LIMIT_TOP);

        // directed: byte extremes, distance 1 overlap, longest-distance copy,
        // match nibble 15 with a zero extension, token with empty literal run
        push_req(OP_TICK, 8'hFF, 1'b0);     // tick with nothing to copy
        seq_items--;
        stream_q.push_back('{OP_BYTE, 8'h20, 1'b0});
        stream_q.push_back('{OP_BYTE, 8'h00, 1'b0});
        stream_q.push_back('{OP_BYTE, 8'hFF, 1'b0});
        gen_count = 2;
        push_req(OP_BYTE, 8'h01, 1'b0);
        push_req(OP_BYTE, 8'h00, 1'b0);
        repeat (4) push_req(OP_TICK, 8'h00, 1'b0);
        gen_count += 4;
        push_sequence(0, 19, gen_count);
        drain_stream();
        wait_idle();

        // random stimulus over several limit settings
        apb_write(23'($urandom_range(200000, 4194304)));
        while (seq_items < RANDOM_ITEMS / 2)
            random_sequence();
        drain_stream();
        wait_idle();

        // limit equal to the exact size after the next sequence
        push_sequence($urandom_range(3, 12), $urandom_range(4, 30), pick_distance());
        apb_write(23'(gen_count));
        drain_stream();
        wait_idle();

        apb_write(LIMIT_TOP);
        while (seq_items < RANDOM_ITEMS)
            random_sequence();
        drain_stream();
        wait_idle();

        // one way for the block to end, then requests that must be ignored
        steady = 1'b0;
        ending = $urandom_range(END_DONE, END_TRUNCATE);
        case (ending)
            END_DONE:
            begin
                d = $urandom_range(1, 14);
                push_req(OP_BYTE, {4'(d), 4'($urandom_range(0, 15))}, 1'b0);
                repeat (d - 1) push_req(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
                push_req(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
            end
            END_EMPTY_RUN:
                push_req(OP_BYTE, {4'd0, 4'($urandom_range(0, 15))}, 1'b1);
            END_LIMIT:
            begin
                apb_write(LIMIT_BOTTOM);
                push_req(OP_BYTE, 8'h30, 1'b0);
                push_req(OP_BYTE, 8'h55, 1'b0);
            end
            END_BAD_DIST:
            begin
                d = (gen_count < 65535 && $urandom_range(0, 1)) ?
                    $urandom_range(gen_count + 1, 65535) : 0;
                push_req(OP_BYTE, 8'h05, 1'b0);
                push_req(OP_BYTE, d[7:0], 1'b0);
                push_req(OP_BYTE, d[15:8], 1'b0);
            end
            END_COPY_HIT:
            begin
                push_req(OP_BYTE, 8'h02, 1'b0);
                push_req(OP_BYTE, 8'h01, 1'b0);
                push_req(OP_BYTE, 8'h00, 1'b0);
                push_req(OP_TICK, 8'h00, 1'b0);
                push_req(OP_BYTE, 8'hA5, 1'b0);
            end
            default:
            begin
                push_req(OP_BYTE, 8'h20, 1'b0);
                push_req(OP_BYTE, 8'h77, 1'b1);
            end
        endcase
        repeat (4)
            push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        drain_stream();
        wait_idle();
        repeat (10) @(negedge clk);

        if (sb.decoded_q.size() > 0)
            sb.fail($sformatf("%0d results never arrived", sb.decoded_q.size()));
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
